### sv/aps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types and constants of the aging packet slot buffer.
// ----------------------------------------------------------------------------
package aps_pkg;

  localparam int SLOT_COUNT       = 4;
  localparam int MAX_PACKET_BYTES = 255;

  localparam int SLOT_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int POS_W     = 8;
  localparam int CNT_W     = POS_W + 1;
  localparam int ADDR_W    = SLOT_W + POS_W;
  localparam int MEM_DEPTH = (1 << ADDR_W);

  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

  localparam logic [15:0] TTL_RESET = 16'd10000;
  localparam logic [CNT_W-1:0] MAX_PKT = CNT_W'(MAX_PACKET_BYTES);

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_PLAIN     = 3'd0,
    ST_STORED    = 3'd1,
    ST_DROP_FULL = 3'd2,
    ST_DROP_LONG = 3'd3,
    ST_NO_PACKET = 3'd4
  } status_t;

  typedef struct packed {
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
    logic              last;
    status_t           status;
    logic              any_stored;
  } cmd_t;

endpackage

### sv/aps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_front
// Time counter, slot table, expiry and push/pop sequencing. Emits one
// memory/result command per accepted transaction.
// ----------------------------------------------------------------------------
module aps_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [1:0]        in_op,
  input  logic [7:0]        in_data_byte,
  input  logic              in_push_last,
  input  logic [7:0]        in_request_len,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_ttl_ticks,
  output aps_pkg::cmd_t     cmd
);
  import aps_pkg::*;

  logic [15:0]           ttl_r;
  logic [31:0]           time_r, time_nxt;
  logic [SLOT_COUNT-1:0] used_r, used_nxt, used_e, expire;
  logic [31:0]           stamp_r [SLOT_COUNT];
  logic [7:0]            length_r [SLOT_COUNT];
  logic [7:0]            length_nxt [SLOT_COUNT];

  logic              push_busy_r, push_busy_nxt;
  logic              push_full_r, push_full_nxt;
  logic [SLOT_W-1:0] push_slot_r, push_slot_nxt;
  logic [CNT_W-1:0]  push_cnt_r, push_cnt_nxt;

  logic              pop_busy_r, pop_busy_nxt;
  logic [SLOT_W-1:0] pop_slot_r, pop_slot_nxt;
  logic [POS_W-1:0]  pop_pos_r, pop_pos_nxt;
  logic [POS_W-1:0]  pop_len_r, pop_len_nxt;

  logic              free_found, used_found;
  logic [SLOT_W-1:0] free_idx, used_idx;
  logic              stamp_we;
  logic [SLOT_W-1:0] stamp_idx;

  assign time_nxt = (in_op == OP_TICK) ? time_r + 32'd1 : time_r;

  always_comb begin
    for (int s = 0; s < SLOT_COUNT; s++) begin
      expire[s] = used_r[s] && !(pop_busy_r && pop_slot_r == SLOT_W'(s)) &&
                  ((time_nxt - stamp_r[s]) > {16'd0, ttl_r});
    end
    used_e = used_r & ~expire;
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    used_found = 1'b0;
    used_idx   = '0;
    for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
      if (!used_e[s]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(s);
      end
      if (used_e[s]) begin
        used_found = 1'b1;
        used_idx   = SLOT_W'(s);
      end
    end
  end

  always_comb begin
    logic              cur_full;
    logic [SLOT_W-1:0] cur_slot;
    logic [CNT_W-1:0]  cur_cnt, cnt2;
    logic [POS_W-1:0]  slen, plen;
    logic [POS_W:0]    pos1;

    used_nxt      = used_e;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      length_nxt[s] = expire[s] ? 8'd0 : length_r[s];
    end
    push_busy_nxt = push_busy_r;
    push_full_nxt = push_full_r;
    push_slot_nxt = push_slot_r;
    push_cnt_nxt  = push_cnt_r;
    pop_busy_nxt  = pop_busy_r;
    pop_slot_nxt  = pop_slot_r;
    pop_pos_nxt   = pop_pos_r;
    pop_len_nxt   = pop_len_r;
    stamp_we      = 1'b0;
    stamp_idx     = free_idx;
    cur_full      = push_full_r;
    cur_slot      = push_slot_r;
    cur_cnt       = push_cnt_r;
    cnt2          = push_cnt_r;
    slen          = length_r[used_idx];
    plen          = pop_len_r;
    pos1          = {1'b0, pop_pos_r} + 9'd1;
    cmd           = '0;
    cmd.status    = ST_PLAIN;

    case (in_op)
      OP_PUSH: begin
        if (!push_busy_r) begin
          cur_full = !free_found;
          cur_slot = free_found ? free_idx : '0;
          cur_cnt  = '0;
          stamp_we = free_found;
        end
        cmd.mem_we = !cur_full && (cur_cnt < MAX_PKT);
        cmd.addr   = {cur_slot, cur_cnt[POS_W-1:0]};
        cmd.wdata  = in_data_byte;
        cnt2       = (cur_cnt <= MAX_PKT) ? cur_cnt + CNT_W'(1) : cur_cnt;
        if (in_push_last) begin
          if (cnt2 > MAX_PKT) begin
            cmd.status = ST_DROP_LONG;
          end else if (cur_full) begin
            cmd.status = ST_DROP_FULL;
          end else begin
            cmd.status           = ST_STORED;
            used_nxt[cur_slot]   = 1'b1;
            length_nxt[cur_slot] = cnt2[POS_W-1:0];
          end
          push_busy_nxt = 1'b0;
          push_full_nxt = 1'b0;
          push_cnt_nxt  = '0;
        end else begin
          push_busy_nxt = 1'b1;
          push_full_nxt = cur_full;
          push_slot_nxt = cur_slot;
          push_cnt_nxt  = cnt2;
        end
      end
      OP_POP: begin
        if (!pop_busy_r) begin
          if (!used_found) begin
            cmd.status = ST_NO_PACKET;
          end else begin
            plen = (in_request_len == 8'd0 || slen < in_request_len) ?
                   slen : in_request_len;
            pop_busy_nxt = 1'b1;
            pop_slot_nxt = used_idx;
            pop_pos_nxt  = '0;
            pop_len_nxt  = plen;
            pos1         = 9'd1;
          end
        end
        if (pop_busy_nxt) begin
          cmd.mem_re = 1'b1;
          cmd.addr   = {pop_slot_nxt, pop_pos_nxt};
          if (pos1 >= {1'b0, plen}) begin
            cmd.last                 = 1'b1;
            used_nxt[pop_slot_nxt]   = 1'b0;
            length_nxt[pop_slot_nxt] = 8'd0;
            pop_busy_nxt             = 1'b0;
            pop_pos_nxt              = '0;
            pop_len_nxt              = '0;
          end else begin
            pop_pos_nxt = pos1[POS_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase

    cmd.any_stored = |used_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r       <= TTL_RESET;
      time_r      <= '0;
      used_r      <= '0;
      push_busy_r <= 1'b0;
      push_full_r <= 1'b0;
      push_slot_r <= '0;
      push_cnt_r  <= '0;
      pop_busy_r  <= 1'b0;
      pop_slot_r  <= '0;
      pop_pos_r   <= '0;
      pop_len_r   <= '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        length_r[s] <= 8'd0;
      end
    end else begin
      if (cfg_we) begin
        ttl_r <= cfg_ttl_ticks;
      end
      if (accept) begin
        time_r      <= time_nxt;
        used_r      <= used_nxt;
        push_busy_r <= push_busy_nxt;
        push_full_r <= push_full_nxt;
        push_slot_r <= push_slot_nxt;
        push_cnt_r  <= push_cnt_nxt;
        pop_busy_r  <= pop_busy_nxt;
        pop_slot_r  <= pop_slot_nxt;
        pop_pos_r   <= pop_pos_nxt;
        pop_len_r   <= pop_len_nxt;
        for (int s = 0; s < SLOT_COUNT; s++) begin
          length_r[s] <= length_nxt[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && stamp_we) begin
      stamp_r[stamp_idx] <= time_nxt;
    end
  end

endmodule

### sv/aps_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_cmd_fifo
// Short command queue between the front and back sections.
// ----------------------------------------------------------------------------
module aps_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  aps_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          rd_en,
  output aps_pkg::cmd_t rd_cmd,
  output logic          empty
);
  import aps_pkg::*;

  cmd_t                 q_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMD_PTR_W:0]   count_r, count_nxt;
  logic                 do_wr, do_rd;

  assign full   = (count_r == (CMD_PTR_W+1)'(CMD_DEPTH));
  assign empty  = (count_r == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_cmd = q_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + (CMD_PTR_W+1)'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - (CMD_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + CMD_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + CMD_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

### sv/aps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_back
// Packet byte memory, result register; one command per cycle, pop permitting.
// ----------------------------------------------------------------------------
module aps_back (
  input  logic          clk,
  input  logic          rst_n,
  input  aps_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_take,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic [2:0]    out_status,
  output logic          out_any_stored
);
  import aps_pkg::*;

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rdata_r;
  logic       valid_r;
  cmd_t       res_r;

  assign cmd_take       = !cmd_empty && (!valid_r || pop);
  assign empty          = !valid_r;
  assign out_byte       = res_r.mem_re ? rdata_r : 8'd0;
  assign out_last       = res_r.last;
  assign out_status     = res_r.status;
  assign out_any_stored = res_r.any_stored;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd_take) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      res_r <= cmd;
      if (cmd.mem_we) begin
        mem[cmd.addr] <= cmd.wdata;
      end
      if (cmd.mem_re) begin
        rdata_r <= mem[cmd.addr];
      end
    end
  end

endmodule

### sv/aging_packet_slot_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_packet_slot_buffer
// Packet slot store with tick-based expiry; bytes pushed and popped one
// transaction at a time.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  input    push / full             in_op, in_data_byte, in_push_last,
//                                   in_request_len
//  result   empty / pop             out_byte, out_last, out_status,
//                                   out_any_stored
//  config   cfg_valid / cfg_ready   cfg_ttl_ticks
//
// One transaction per cycle sustained while full is low; a result reaches
// the output ports via the queue entry, then the result register.
// Slot table, expiry and time counter update in the cycle of acceptance.
// Synchronous active-low reset; no clearing pass, the byte memory is not reset.
// A stalled result side fills the two-entry command queue, then raises full.
// ----------------------------------------------------------------------------
module aging_packet_slot_buffer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_data_byte,
  input  logic        in_push_last,
  input  logic [7:0]  in_request_len,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [2:0]  out_status,
  output logic        out_any_stored,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_ttl_ticks
);
  import aps_pkg::*;

  cmd_t front_cmd, back_cmd;
  logic accept, q_full, q_empty, q_take;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  aps_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_op          (in_op),
    .in_data_byte   (in_data_byte),
    .in_push_last   (in_push_last),
    .in_request_len (in_request_len),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_ttl_ticks  (cfg_ttl_ticks),
    .cmd            (front_cmd)
  );

  aps_cmd_fifo u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (accept),
    .wr_cmd (front_cmd),
    .full   (q_full),
    .rd_en  (q_take),
    .rd_cmd (back_cmd),
    .empty  (q_empty)
  );

  aps_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (back_cmd),
    .cmd_empty      (q_empty),
    .cmd_take       (q_take),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_status     (out_status),
    .out_any_stored (out_any_stored)
  );

endmodule

### sim/aging_packet_slot_buffer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_packet_slot_buffer_test
// Self-checking bench: directed and random byte traffic against a cycle-free
// predictor of the slot table, expiry, push and pop engines.
// ----------------------------------------------------------------------------
module aging_packet_slot_buffer_test;
  import aps_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;  // unused opcode
  localparam int STALL_LIMIT = 500;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    status_t    status;
    logic       stored;
  } slot_result_t;

  class slot_buffer_scoreboard;
    logic [15:0]       ttl;
    logic [31:0]       now;
    logic [SLOT_COUNT-1:0] used;
    logic [31:0]       stamp [SLOT_COUNT];
    int                length [SLOT_COUNT];
    logic [7:0]        bytes [SLOT_COUNT][256];
    bit                push_busy, push_full, pop_busy;
    int                push_slot, push_count, pop_slot, pop_pos, pop_len;
    slot_result_t      predicted_outputs [$];
    int                errors;

    function new();
      ttl = TTL_RESET;
      now = '0;
      used = '0;
      foreach (length[s]) length[s] = 0;
      push_busy = 0;
      push_full = 0;
      pop_busy = 0;
      push_slot = 0;
      push_count = 0;
      pop_slot = 0;
      pop_pos = 0;
      pop_len = 0;
      errors = 0;
    endfunction

    function int pending();
      return predicted_outputs.size();
    endfunction

    function void apply_item(logic [1:0] op, logic [7:0] data, logic last,
                             logic [7:0] req);
      slot_result_t r;
      logic [31:0]  age;
      int           found;
      r = '0;
      r.status = ST_PLAIN;
      if (op == OP_TICK) now = now + 32'd1;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        age = now - stamp[s];
        if (used[s] && !(pop_busy && pop_slot == s) && age > {16'd0, ttl}) begin
          used[s] = 1'b0;
          length[s] = 0;
        end
      end
      if (op == OP_PUSH) begin
        if (!push_busy) begin
          push_busy = 1;
          push_full = 1;
          push_count = 0;
          push_slot = 0;
          for (int s = 0; s < SLOT_COUNT; s++) begin
            if (!used[s] && push_full) begin
              push_slot = s;
              push_full = 0;
              stamp[s] = now;
            end
          end
        end
        if (!push_full && push_count < MAX_PACKET_BYTES)
          bytes[push_slot][push_count] = data;
        if (push_count <= MAX_PACKET_BYTES) push_count++;
        if (last) begin
          if (push_count > MAX_PACKET_BYTES) begin
            r.status = ST_DROP_LONG;
          end else if (push_full) begin
            r.status = ST_DROP_FULL;
          end else begin
            used[push_slot] = 1'b1;
            length[push_slot] = push_count;
            r.status = ST_STORED;
          end
          push_busy = 0;
          push_full = 0;
          push_count = 0;
        end
      end else if (op == OP_POP) begin
        if (!pop_busy) begin
          found = -1;
          for (int s = 0; s < SLOT_COUNT; s++)
            if (used[s] && found < 0) found = s;
          if (found < 0) begin
            r.status = ST_NO_PACKET;
          end else begin
            pop_busy = 1;
            pop_slot = found;
            pop_pos = 0;
            pop_len = (req == 0 || length[found] < req) ? length[found] : req;
          end
        end
        if (pop_busy) begin
          r.data = bytes[pop_slot][pop_pos & 255];
          pop_pos++;
          if (pop_pos >= pop_len) begin
            r.last = 1'b1;
            used[pop_slot] = 1'b0;
            length[pop_slot] = 0;
            pop_busy = 0;
            pop_pos = 0;
            pop_len = 0;
          end
        end
      end
      r.stored = |used;
      predicted_outputs.push_back(r);
    endfunction

    function void check_result(logic [7:0] data, logic last, logic [2:0] status,
                               logic stored);
      slot_result_t e;
      if (predicted_outputs.size() == 0) begin
        $error("result transaction with no prediction pending");
        errors++;
        return;
      end
      e = predicted_outputs.pop_front();
      if (data !== e.data) begin
        $error("out_byte expected %0d got %0d", e.data, data);
        errors++;
      end
      if (last !== e.last) begin
        $error("out_last expected %0d got %0d", e.last, last);
        errors++;
      end
      if (status !== e.status) begin
        $error("out_status expected %0d got %0d", e.status, status);
        errors++;
      end
      if (stored !== e.stored) begin
        $error("out_any_stored expected %0d got %0d", e.stored, stored);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [1:0]  in_op;
  logic [7:0]  in_data_byte;
  logic        in_push_last;
  logic [7:0]  in_request_len;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [2:0]  out_status;
  logic        out_any_stored;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_ttl_ticks;

  slot_buffer_scoreboard board;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  int idle_cycles = 0;

  aging_packet_slot_buffer DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_op          (in_op),
    .in_data_byte   (in_data_byte),
    .in_push_last   (in_push_last),
    .in_request_len (in_request_len),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_status     (out_status),
    .out_any_stored (out_any_stored),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_ttl_ticks  (cfg_ttl_ticks)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    pop = rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) board.check_result(out_byte, out_last, out_status, out_any_stored);
      if (push && !full) board.apply_item(in_op, in_data_byte, in_push_last, in_request_len);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk); while (idle_cycles < STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] data,
                           input logic last, input logic [7:0] req);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    in_op = op;
    in_data_byte = data;
    in_push_last = last;
    in_request_len = req;
    do @(posedge clk); while (full);
    @(negedge clk);
    if (op != OP_NOP) items_sent++;
  endtask

  task automatic drain_results();
    push = 1'b0;
    do @(negedge clk); while (board.pending() != 0);
  endtask

  task automatic write_ttl(input logic [15:0] value);
    cfg_valid = 1'b1;
    cfg_ttl_ticks = value;
    do @(posedge clk); while (!cfg_ready);
    board.ttl = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_random(input int target);
    int         stop_at;
    int         len;
    int         pick;
    logic [7:0] first_req;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 2) drain_results();
      pick = $urandom_range(99);
      if (pick < 35) begin
        len = ($urandom_range(99) < 2) ? $urandom_range(258, 250) : $urandom_range(6, 1);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(99) < 8)
            send_item($urandom_range(1) ? OP_TICK : OP_POP, $urandom_range(255),
                      $urandom_range(1), $urandom_range(255));
          send_item(OP_PUSH, $urandom_range(255), i == len - 1, $urandom_range(255));
        end
      end else if (pick < 70) begin
        case ($urandom_range(3))
          0: first_req = 8'd0;
          3: first_req = $urandom_range(255);
          default: first_req = $urandom_range(8, 1);
        endcase
        repeat ($urandom_range(6, 1)) begin
          send_item(OP_POP, $urandom_range(255), $urandom_range(1), first_req);
          first_req = $urandom_range(255);
        end
      end else if (pick < 92) begin
        repeat ($urandom_range(3, 1))
          send_item(OP_TICK, $urandom_range(255), $urandom_range(1), $urandom_range(255));
      end else begin
        send_item(OP_NOP, $urandom_range(255), $urandom_range(1), $urandom_range(255));
      end
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_op = OP_TICK;
    in_data_byte = '0;
    in_push_last = 1'b0;
    in_request_len = '0;
    cfg_valid = 1'b0;
    cfg_ttl_ticks = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty pop, fill, full drop, expiry with a pop in flight
    write_ttl(16'd2);
    send_item(OP_POP, 8'h00, 1'b0, 8'd255);
    send_item(OP_NOP, 8'hFF, 1'b1, 8'hFF);
    send_item(OP_PUSH, 8'h00, 1'b0, 8'd0);
    send_item(OP_PUSH, 8'hFF, 1'b1, 8'd0);
    send_item(OP_PUSH, 8'h5A, 1'b1, 8'd0);
    send_item(OP_PUSH, 8'hA5, 1'b1, 8'd0);
    send_item(OP_PUSH, 8'h3C, 1'b1, 8'd0);
    send_item(OP_PUSH, 8'h11, 1'b0, 8'd0);
    send_item(OP_PUSH, 8'h22, 1'b1, 8'd0);
    send_item(OP_POP, 8'h00, 1'b0, 8'd255);
    repeat (3) send_item(OP_TICK, 8'h00, 1'b0, 8'd0);
    send_item(OP_POP, 8'h00, 1'b0, 8'd0);
    send_item(OP_PUSH, 8'h77, 1'b0, 8'd0);
    send_item(OP_PUSH, 8'h88, 1'b1, 8'd0);
    send_item(OP_POP, 8'h00, 1'b0, 8'd1);
    send_item(OP_POP, 8'h00, 1'b0, 8'd0);
    send_item(OP_PUSH, 8'h99, 1'b1, 8'd0);
    send_item(OP_POP, 8'h00, 1'b1, 8'd0);

    drain_results();
    write_ttl(16'hFFFF);
    send_idle_pct = 37;
    recv_idle_pct = 67;
    run_random(250);

    drain_results();
    write_ttl(16'd0);
    send_idle_pct = 67;
    recv_idle_pct = 37;
    run_random(250);

    drain_results();
    write_ttl($urandom_range(40, 3));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(250);

    drain_results();
    repeat (8) @(negedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/aps_pkg.sv
sv/aps_front.sv
sv/aps_cmd_fifo.sv
sv/aps_back.sv
sv/aging_packet_slot_buffer.sv
sim/aging_packet_slot_buffer_test.sv
